[src/kti_pkg.sv]
// ----------------------------------------------------------------------------
// kti_pkg
// shared codes, widths and helpers of the knot table interpolator
// ----------------------------------------------------------------------------
package kti_pkg;

  localparam int QUOT_W = 31;   // fraction t in q1.30, up to and including 1.0

  localparam logic       CMD_LOAD  = 1'b0;
  localparam logic       CMD_QUERY = 1'b1;

  localparam logic [1:0] MODE_STEP       = 2'd0;
  localparam logic [1:0] MODE_LINEAR     = 2'd1;
  localparam logic [1:0] MODE_SPLINE     = 2'd2;
  localparam logic [1:0] MODE_LINEAR_ALT = 2'd3;   // spare code, runs as linear

  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_KNOTS  = 2'd1;
  localparam logic [1:0] CFG_SERIES = 2'd2;
  localparam logic [1:0] CFG_SPARE  = 2'd3;

  // search phase: what the position just read means
  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_UP    = 3'd1,
    PH_UPEND = 3'd2,
    PH_DOWN  = 3'd3,
    PH_DNEND = 3'd4,
    PH_BIS   = 3'd5
  } phase_t;

  // multiplier steps of one segment evaluation
  typedef enum logic [2:0] {
    MS_DYT = 3'd0,
    MS_K0H = 3'd1,
    MS_K1H = 3'd2,
    MS_AU  = 3'd3,
    MS_BT  = 3'd4,
    MS_TU  = 3'd5,
    MS_MW  = 3'd6
  } mstep_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[src/kti_in_if.sv]
// ----------------------------------------------------------------------------
// kti_in_if
// command channel: load and query items
// ----------------------------------------------------------------------------
interface kti_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [5:0]         knot_index;
  logic [1:0]         series_index;
  logic signed [31:0] knot_pos;
  logic signed [31:0] knot_value;
  logic signed [31:0] knot_slope;
  logic signed [31:0] query_pos;

  modport source (
    output valid, cmd, knot_index, series_index, knot_pos, knot_value, knot_slope,
    query_pos,
    input  ready
  );
  modport sink (
    input  valid, cmd, knot_index, series_index, knot_pos, knot_value, knot_slope,
    query_pos,
    output ready
  );
endinterface

[src/kti_out_if.sv]
// ----------------------------------------------------------------------------
// kti_out_if
// result channel: one transfer per series of a query
// ----------------------------------------------------------------------------
interface kti_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               status;
  logic [1:0]         series;
  logic               last;

  modport source (output valid, value, status, series, last, input ready);
  modport sink   (input valid, value, status, series, last, output ready);
endinterface

[src/kti_ram.sv]
// ----------------------------------------------------------------------------
// kti_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module kti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/kti_div.sv]
// ----------------------------------------------------------------------------
// kti_div
// restoring divider, one quotient bit per cycle, for num <= den
// ----------------------------------------------------------------------------
module kti_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [32:0]                num,
  input  logic [32:0]                den,
  output logic [kti_pkg::QUOT_W-1:0] quot,
  output logic                       done
);

  logic        busy;
  logic [34:0] rem;
  logic [32:0] den_r;
  logic [4:0]  cnt;
  logic        ge;
  logic [34:0] rem_s;

  assign ge    = rem >= {2'b00, den_r};
  assign rem_s = ge ? rem - {2'b00, den_r} : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 5'(kti_pkg::QUOT_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= {2'b00, num};
      den_r <= den;
      cnt   <= '0;
    end else if (busy) begin
      rem  <= {rem_s[33:0], 1'b0};
      quot <= {quot[kti_pkg::QUOT_W-2:0], ge};
      cnt  <= cnt + 5'd1;
    end
  end

endmodule

[src/knot_table_interpolator.sv]
// ----------------------------------------------------------------------------
// knot_table_interpolator
// knot table with hunt and bisection search, step / linear / hermite results
// ----------------------------------------------------------------------------
// load: taken while idle; writes the knot rams in the transfer cycle
// query: table probes in the hunt, then in the bisection, then segment reads
//   and, for linear and spline, the serial divider for t
// per series: step reads a value; linear and spline share one 36x33 multiplier
// one query at a time; results leave through an output register
// reset: mode linear, 2 knots, 1 series, search hint 0; tables are not cleared
// ----------------------------------------------------------------------------
module knot_table_interpolator #(
  parameter int MAX_KNOTS  = 64,
  parameter int MAX_SERIES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  kti_in_if.sink      cmd_ch,
  kti_out_if.source   res_ch
);

  localparam int KW = $clog2(MAX_KNOTS);
  localparam int CW = $clog2(MAX_KNOTS + 1);
  localparam int IW = KW + 2;
  localparam int AW = $clog2(MAX_SERIES * MAX_KNOTS);
  localparam int SL = (MAX_SERIES < 4) ? MAX_SERIES : 4;

  localparam logic signed [50:0] AB_HI = 51'sd4294967296;
  localparam logic signed [50:0] AB_LO = -51'sd4294967296;

  // one-hot sequencer states
  typedef enum logic [16:0] {
    ST_IDLE  = 17'h00001,
    ST_PROBE = 17'h00002,
    ST_HUNT  = 17'h00004,
    ST_BSEL  = 17'h00008,
    ST_X1A   = 17'h00010,
    ST_X1W   = 17'h00020,
    ST_X0A   = 17'h00040,
    ST_X0W   = 17'h00080,
    ST_DIV   = 17'h00100,
    ST_VSET  = 17'h00200,
    ST_VA    = 17'h00400,
    ST_V0W   = 17'h00800,
    ST_V1A   = 17'h01000,
    ST_V1W   = 17'h02000,
    ST_MUL   = 17'h04000,
    ST_ACC   = 17'h08000,
    ST_EMIT  = 17'h10000
  } state_t;

  function automatic logic signed [33:0] clamp_ab(input logic signed [50:0] v);
    logic signed [33:0] r;
    if (v > AB_HI) begin
      r = 34'sd4294967296;
    end else if (v < AB_LO) begin
      r = -34'sd4294967296;
    end else begin
      r = v[33:0];
    end
    return r;
  endfunction

  // configuration registers
  logic [1:0] mode;
  logic [6:0] knot_count;
  logic [2:0] series_count;

  state_t state;
  kti_pkg::phase_t phase;
  kti_pkg::mstep_t ms;

  // search registers
  logic [KW-1:0] hint;
  logic [KW-1:0] i0, i1;
  logic [IW-1:0] inc;
  logic [KW-1:0] pos_addr;
  logic [KW-1:0] seg;
  logic signed [31:0] q;
  logic bad, hold;

  // segment registers
  logic signed [31:0] x1, y0, k0, k1;
  logic signed [32:0] h, dy;
  logic [32:0] e_cl;
  logic [kti_pkg::QUOT_W-1:0] t;
  logic signed [35:0] acc_r, mm;
  logic signed [33:0] aa, bb;
  logic [30:0] w;
  logic signed [68:0] prod;
  logic signed [31:0] res_val;
  logic div_start;

  // series loop and output register
  logic [1:0] s_cnt;
  logic [AW-1:0] v_addr;
  logic out_valid;
  logic signed [31:0] out_value;
  logic out_status;
  logic [1:0] out_series;
  logic out_last;

  // clamped configuration
  logic [CW-1:0] n_c;
  logic [KW-1:0] nm1;
  logic [2:0]    sc_c;
  logic          step_m, cubic_m, is_last;

  always_comb begin
    if (knot_count == 7'd0) begin
      n_c = CW'(1);
    end else if (int'(knot_count) > MAX_KNOTS) begin
      n_c = CW'(MAX_KNOTS);
    end else begin
      n_c = CW'(knot_count);
    end
    if (series_count == 3'd0) begin
      sc_c = 3'd1;
    end else if (int'(series_count) > SL) begin
      sc_c = 3'(SL);
    end else begin
      sc_c = series_count;
    end
  end

  assign nm1     = KW'(n_c - CW'(1));
  assign step_m  = (mode == kti_pkg::MODE_STEP);
  assign cubic_m = (mode == kti_pkg::MODE_SPLINE);
  assign is_last = (3'(s_cnt) + 3'd1) == sc_c;

  // table rams: positions, and value with slope side by side
  logic          load_go, pos_we;
  logic [31:0]   pos_rdata, val_rdata, slp_rdata;
  logic [63:0]   vs_rdata;
  logic [AW-1:0] vw_addr;
  logic signed [31:0] xd;

  assign load_go = cmd_ch.valid && cmd_ch.ready && cmd_ch.cmd == kti_pkg::CMD_LOAD
                   && int'(cmd_ch.knot_index) < MAX_KNOTS
                   && int'(cmd_ch.series_index) < MAX_SERIES;
  assign pos_we  = load_go && cmd_ch.series_index == 2'd0;
  assign vw_addr = AW'(int'(cmd_ch.series_index) * MAX_KNOTS + int'(cmd_ch.knot_index));
  assign xd      = $signed(pos_rdata);
  assign val_rdata = vs_rdata[31:0];
  assign slp_rdata = vs_rdata[63:32];

  kti_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_pos_ram (
    .clk(clk), .we(pos_we), .waddr(KW'(cmd_ch.knot_index)), .wdata(cmd_ch.knot_pos),
    .raddr(pos_addr), .rdata(pos_rdata)
  );

  kti_ram #(.WIDTH(64), .DEPTH(MAX_SERIES * MAX_KNOTS)) u_vs_ram (
    .clk(clk), .we(load_go), .waddr(vw_addr),
    .wdata({cmd_ch.knot_slope, cmd_ch.knot_value}),
    .raddr(v_addr), .rdata(vs_rdata)
  );

  // fraction divider, t = (q - x0) * 2^30 / (x1 - x0)
  logic [kti_pkg::QUOT_W-1:0] quot;
  logic div_done;

  kti_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(e_cl), .den(h),
    .quot(quot), .done(div_done)
  );

  // search helpers
  logic [IW-1:0] inc2, i1n;
  logic [KW:0]   mid_sum;
  logic [KW-1:0] hint_c;
  assign inc2    = inc << 1;
  assign i1n     = IW'(i1) + inc2;
  assign mid_sum = (KW+1)'(i0) + (KW+1)'(i1);
  assign hint_c  = (hint > nm1) ? nm1 : hint;

  // segment width and offset at the x0 read
  logic signed [32:0] h_n, e_n;
  assign h_n = {x1[31], x1} - {xd[31], xd};
  assign e_n = {q[31], q} - {xd[31], xd};

  // shared multiplier operands
  logic [30:0] u;
  logic signed [35:0] op_a;
  logic signed [32:0] op_b;
  assign u = 31'(31'h40000000 - t);

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (ms)
      kti_pkg::MS_DYT: begin op_a = 36'(dy);  op_b = {2'b00, t}; end
      kti_pkg::MS_K0H: begin op_a = 36'(k0);  op_b = h;          end
      kti_pkg::MS_K1H: begin op_a = 36'(k1);  op_b = h;          end
      kti_pkg::MS_AU:  begin op_a = 36'(aa);  op_b = {2'b00, u}; end
      kti_pkg::MS_BT:  begin op_a = 36'(bb);  op_b = {2'b00, t}; end
      kti_pkg::MS_TU:  begin op_a = {5'b0, t}; op_b = {2'b00, u}; end
      kti_pkg::MS_MW:  begin op_a = mm;       op_b = {2'b00, w}; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  // product rounding, half up
  logic signed [69:0] prod_x, r30, r16;
  logic signed [35:0] acc_n;
  logic signed [50:0] a_raw, b_raw;
  logic signed [39:0] fin;
  assign prod_x = 70'(prod);
  assign r30    = (prod_x + 70'sd536870912) >>> 30;
  assign r16    = (prod_x + 70'sd32768) >>> 16;
  assign acc_n  = 36'(y0) + r30[35:0];
  assign a_raw  = r16[50:0] - 51'(dy);
  assign b_raw  = 51'(dy) - r16[50:0];
  assign fin    = 40'(acc_r) + r30[39:0];

  assign cmd_ch.ready  = (state == ST_IDLE);
  assign res_ch.valid  = out_valid;
  assign res_ch.value  = out_value;
  assign res_ch.status = out_status;
  assign res_ch.series = out_series;
  assign res_ch.last   = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      mode         <= kti_pkg::MODE_LINEAR;
      knot_count   <= 7'd2;
      series_count <= 3'd1;
      hint         <= '0;
      out_valid    <= 1'b0;
      div_start    <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (out_valid && res_ch.ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          kti_pkg::CFG_MODE:   mode         <= cfg_data[1:0];
          kti_pkg::CFG_KNOTS:  knot_count   <= cfg_data;
          kti_pkg::CFG_SERIES: series_count <= cfg_data[2:0];
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (cmd_ch.valid && cmd_ch.cmd == kti_pkg::CMD_QUERY) begin
            q     <= cmd_ch.query_pos;
            s_cnt <= 2'd0;
            bad   <= 1'b0;
            hold  <= 1'b0;
            if (!step_m && n_c < CW'(2)) begin
              // linear and spline need a segment
              bad   <= 1'b1;
              state <= ST_EMIT;
            end else begin
              i0       <= hint_c;
              i1       <= hint_c;
              pos_addr <= hint_c;
              phase    <= kti_pkg::PH_START;
              state    <= ST_PROBE;
            end
          end
        end

        // ram latches the probe address
        ST_PROBE: state <= ST_HUNT;

        ST_HUNT: begin
          state <= ST_BSEL;
          case (phase)
            kti_pkg::PH_START: begin
              if (xd <= q) begin
                if (i0 == nm1) begin
                  // at or above the last knot
                  if (step_m || xd == q) begin
                    seg   <= nm1;
                    hold  <= 1'b1;
                    state <= ST_VSET;
                  end else begin
                    bad   <= 1'b1;
                    state <= ST_EMIT;
                  end
                end else begin
                  i1       <= i0 + KW'(1);
                  pos_addr <= i0 + KW'(1);
                  inc      <= IW'(1);
                  phase    <= kti_pkg::PH_UP;
                  state    <= ST_PROBE;
                end
              end else if (i0 == '0) begin
                bad   <= 1'b1;
                state <= ST_EMIT;
              end else begin
                i0       <= i0 - KW'(1);
                pos_addr <= i0 - KW'(1);
                inc      <= IW'(1);
                phase    <= kti_pkg::PH_DOWN;
                state    <= ST_PROBE;
              end
            end
            kti_pkg::PH_UP: begin
              if (xd < q) begin
                i0    <= i1;
                inc   <= inc2;
                state <= ST_PROBE;
                if (i1n >= IW'(n_c)) begin
                  i1       <= nm1;
                  pos_addr <= nm1;
                  phase    <= kti_pkg::PH_UPEND;
                end else begin
                  i1       <= KW'(i1n);
                  pos_addr <= KW'(i1n);
                end
              end
            end
            kti_pkg::PH_UPEND: begin
              if (xd < q) begin
                if (step_m) begin
                  seg   <= nm1;
                  hold  <= 1'b1;
                  state <= ST_VSET;
                end else begin
                  bad   <= 1'b1;
                  state <= ST_EMIT;
                end
              end
            end
            kti_pkg::PH_DOWN: begin
              if (xd > q) begin
                i1    <= i0;
                inc   <= inc2;
                state <= ST_PROBE;
                if (IW'(i0) < inc2) begin
                  i0       <= '0;
                  pos_addr <= '0;
                  phase    <= kti_pkg::PH_DNEND;
                end else begin
                  i0       <= KW'(IW'(i0) - inc2);
                  pos_addr <= KW'(IW'(i0) - inc2);
                end
              end
            end
            kti_pkg::PH_DNEND: begin
              if (xd > q) begin
                bad   <= 1'b1;
                state <= ST_EMIT;
              end
            end
            kti_pkg::PH_BIS: begin
              if (xd < q) begin
                i0 <= pos_addr;
              end else begin
                i1 <= pos_addr;
              end
            end
            default: state <= ST_BSEL;
          endcase
        end

        // bisection step or segment found
        ST_BSEL: begin
          if ((KW+1)'(i1) > (KW+1)'(i0) + (KW+1)'(1)) begin
            pos_addr <= KW'(mid_sum >> 1);
            phase    <= kti_pkg::PH_BIS;
            state    <= ST_PROBE;
          end else begin
            hint     <= i0;
            seg      <= i0;
            pos_addr <= i0 + KW'(1);
            state    <= ST_X1A;
          end
        end

        ST_X1A: state <= ST_X1W;

        ST_X1W: begin
          if (step_m) begin
            // a query on the next knot takes that knot
            if (xd == q) begin
              seg <= seg + KW'(1);
            end
            hold  <= 1'b1;
            state <= ST_VSET;
          end else begin
            x1       <= xd;
            pos_addr <= seg;
            state    <= ST_X0A;
          end
        end

        ST_X0A: state <= ST_X0W;

        ST_X0W: begin
          h <= h_n;
          if (h_n > 33'sd0) begin
            if (e_n < 33'sd0) begin
              e_cl <= '0;
            end else if (e_n > h_n) begin
              e_cl <= h_n;
            end else begin
              e_cl <= e_n;
            end
            div_start <= 1'b1;
            state     <= ST_DIV;
          end else begin
            t     <= '0;
            state <= ST_VSET;
          end
        end

        ST_DIV: begin
          if (div_done) begin
            t     <= quot;
            state <= ST_VSET;
          end
        end

        ST_VSET: begin
          v_addr <= AW'(int'(s_cnt) * MAX_KNOTS + int'(seg));
          state  <= ST_VA;
        end

        ST_VA: state <= ST_V0W;

        ST_V0W: begin
          y0 <= $signed(val_rdata);
          k0 <= $signed(slp_rdata);
          if (hold) begin
            res_val <= $signed(val_rdata);
            state   <= ST_EMIT;
          end else begin
            v_addr <= v_addr + AW'(1);
            state  <= ST_V1A;
          end
        end

        ST_V1A: state <= ST_V1W;

        ST_V1W: begin
          dy    <= 33'($signed(val_rdata)) - 33'(y0);
          k1    <= $signed(slp_rdata);
          ms    <= kti_pkg::MS_DYT;
          state <= ST_MUL;
        end

        ST_MUL: begin
          prod  <= op_a * op_b;
          state <= ST_ACC;
        end

        ST_ACC: begin
          state <= ST_MUL;
          ms    <= kti_pkg::mstep_t'(ms + 3'd1);
          case (ms)
            kti_pkg::MS_DYT: begin
              acc_r <= acc_n;
              if (!cubic_m) begin
                res_val <= kti_pkg::sat32(40'(acc_n));
                state   <= ST_EMIT;
              end
            end
            kti_pkg::MS_K0H: aa <= clamp_ab(a_raw);
            kti_pkg::MS_K1H: bb <= clamp_ab(b_raw);
            kti_pkg::MS_AU:  mm <= r30[35:0];
            kti_pkg::MS_BT:  mm <= mm + r30[35:0];
            kti_pkg::MS_TU:  w  <= r30[30:0];
            kti_pkg::MS_MW: begin
              res_val <= kti_pkg::sat32(fin);
              state   <= ST_EMIT;
            end
            default: state <= ST_EMIT;
          endcase
        end

        // one transfer per series
        ST_EMIT: begin
          if (!out_valid || res_ch.ready) begin
            out_valid  <= 1'b1;
            out_value  <= bad ? 32'sd0 : res_val;
            out_status <= bad;
            out_series <= s_cnt;
            out_last   <= is_last;
            if (is_last) begin
              state <= ST_IDLE;
            end else begin
              s_cnt <= s_cnt + 2'd1;
              state <= bad ? ST_EMIT : ST_VSET;
            end
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
